// ===== rtl/core/aesctr_pkg.sv =====
// ----------------------------------------------------------------------------
// aesctr_pkg
// Shared types, constants and cipher functions for the AES-128 CTR core.
// ----------------------------------------------------------------------------
package aesctr_pkg;

    localparam int NR = 10;

    typedef enum logic [7:0] {
        REG_KEY_UPPER   = 8'd0,
        REG_KEY_LOWER   = 8'd1,
        REG_CTR_UPPER   = 8'd2,
        REG_CTR_LOWER   = 8'd3
    } cfg_reg_t;

    // Payload carried from one round cell to the next
    typedef struct packed {
        logic [127:0] st;
        logic [127:0] data;
        logic [4:0]   nbytes;
    } stage_t;

    localparam logic [7:0] RCON [0:NR] = '{
        8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    localparam logic [7:0] SBOX [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // One cipher round: SubBytes, ShiftRows, MixColumns (skipped on last), AddRoundKey
    function automatic logic [127:0] aes_round(input logic [127:0] st,
                                               input logic [127:0] rk,
                                               input logic last);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [7:0] o [16];
        logic [7:0] a0, a1, a2, a3, all;
        logic [127:0] res;
        for (int i = 0; i < 16; i++) begin
            b[i] = st[127 - 8*i -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[c*4 + r] = SBOX[b[((c + r) % 4)*4 + r]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = t[c*4];
            a1 = t[c*4 + 1];
            a2 = t[c*4 + 2];
            a3 = t[c*4 + 3];
            all = a0 ^ a1 ^ a2 ^ a3;
            o[c*4]     = last ? a0 : a0 ^ all ^ xtime(a0 ^ a1);
            o[c*4 + 1] = last ? a1 : a1 ^ all ^ xtime(a1 ^ a2);
            o[c*4 + 2] = last ? a2 : a2 ^ all ^ xtime(a2 ^ a3);
            o[c*4 + 3] = last ? a3 : a3 ^ all ^ xtime(a3 ^ a0);
        end
        for (int i = 0; i < 16; i++) begin
            res[127 - 8*i -: 8] = o[i];
        end
        aes_round = res ^ rk;
    endfunction

    // One step of the key schedule: previous round key to the next
    function automatic logic [127:0] key_step(input logic [127:0] rk, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;
        w0 = rk[127:96];
        w1 = rk[95:64];
        w2 = rk[63:32];
        w3 = rk[31:0];
        t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        n0 = w0 ^ t;
        n1 = w1 ^ n0;
        n2 = w2 ^ n1;
        n3 = w3 ^ n2;
        key_step = {n0, n1, n2, n3};
    endfunction

endpackage

// ===== rtl/core/aesctr_cell.sv =====
// ----------------------------------------------------------------------------
// aesctr_cell
// One round cell: holds its round key and one block in flight.
// ----------------------------------------------------------------------------
module aesctr_cell import aesctr_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [7:0]   rcon,
    input  logic         last,
    input  logic [127:0] up_rk,
    input  logic         up_valid,
    input  stage_t       up_stage,
    input  logic         down_ready,
    output logic         ready,
    output logic [127:0] rk,
    output logic         valid,
    output stage_t       stage
);

    logic [127:0] rk_reg;
    logic         valid_reg;
    stage_t       stage_reg;

    assign ready = !valid_reg || down_ready;

    // Derive this round's key from the neighbor's key every cycle
    always_ff @(posedge aclk) begin
        rk_reg <= key_step(up_rk, rcon);
    end

    // Advance the block when this cell is free or its contents move on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready && up_valid) begin
            stage_reg.st     <= aes_round(up_stage.st, rk_reg, last);
            stage_reg.data   <= up_stage.data;
            stage_reg.nbytes <= up_stage.nbytes;
        end
    end

    assign rk    = rk_reg;
    assign valid = valid_reg;
    assign stage = stage_reg;

endmodule

// ===== rtl/core/aes128_ctr_keystream_xor_core.sv =====
// ----------------------------------------------------------------------------
// aes128_ctr_keystream_xor_core
// AES-128 counter-mode keystream XOR with a round-per-cell pipeline.
// ----------------------------------------------------------------------------
// Takes one 16-byte block per cycle unless the chain is stalled. Each block encrypts
// the current 128-bit counter through a chain of ten round cells, XORs the
// keystream into the data and zeroes bytes past valid_bytes; a result passes
// the entry stage, ten round cells and the output register, the entry stage
// loading at the input transfer edge. Each cell also derives its own round key
// from its neighbor, so after reset the input stays not ready while the key
// schedule fills, and after a key write the first block may follow in the next
// cycle.
// Bubbles collapse: a stalled output only stops the cells that are full.
module aes128_ctr_keystream_xor_core import aesctr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_restart,
    input  logic [63:0] s_block_upper,
    input  logic [63:0] s_block_lower,
    input  logic [4:0]  s_valid_bytes,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_result_upper,
    output logic [63:0] m_result_lower,
    output logic [4:0]  m_result_bytes
);

    logic [63:0]  key_upper_reg, key_lower_reg, ctr_start_upper_reg, ctr_start_lower_reg;
    logic [127:0] ctr_reg, ctr_cur;
    logic [3:0]   warm_reg;
    logic         warm_done;
    logic         s_accept;
    logic         m_valid_reg;
    logic [127:0] result_reg;
    logic [4:0]   result_bytes_reg;
    logic [127:0] out_ks, out_mask;

    logic         valid_c [0:NR];
    stage_t       stage_c [0:NR];
    logic [127:0] rk_c    [0:NR];
    logic         ready_c [0:NR+1];

    // Configuration writes, always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_upper_reg       <= '0;
            key_lower_reg       <= '0;
            ctr_start_upper_reg <= '0;
            ctr_start_lower_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_KEY_UPPER: key_upper_reg       <= cfg_data;
                REG_KEY_LOWER: key_lower_reg       <= cfg_data;
                REG_CTR_UPPER: ctr_start_upper_reg <= cfg_data;
                REG_CTR_LOWER: ctr_start_lower_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Hold the input off until the key schedule has filled the chain
    assign warm_done = (warm_reg == 4'(NR));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            warm_reg <= '0;
        end else if (!warm_done) begin
            warm_reg <= warm_reg + 4'd1;
        end
    end

    // Counter: reload on restart, advance once per transfer
    assign ctr_cur  = s_restart ? {ctr_start_upper_reg, ctr_start_lower_reg} : ctr_reg;
    assign s_ready  = ready_c[0] && warm_done;
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctr_reg <= '0;
        end else if (s_accept) begin
            ctr_reg <= ctr_cur + 128'd1;
        end
    end

    // Entry stage: initial AddRoundKey
    assign rk_c[0]    = {key_upper_reg, key_lower_reg};
    assign ready_c[0] = !valid_c[0] || ready_c[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_c[0] <= 1'b0;
        end else if (ready_c[0]) begin
            valid_c[0] <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            stage_c[0].st     <= ctr_cur ^ rk_c[0];
            stage_c[0].data   <= {s_block_upper, s_block_lower};
            stage_c[0].nbytes <= s_valid_bytes;
        end
    end

    // Round cells
    for (genvar i = 1; i <= NR; i++) begin : g_round
        aesctr_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .rcon       (RCON[i]),
            .last       (1'(i == NR)),
            .up_rk      (rk_c[i-1]),
            .up_valid   (valid_c[i-1]),
            .up_stage   (stage_c[i-1]),
            .down_ready (ready_c[i+1]),
            .ready      (ready_c[i]),
            .rk         (rk_c[i]),
            .valid      (valid_c[i]),
            .stage      (stage_c[i])
        );
    end

    // Output register: XOR keystream and drop bytes past the count
    assign ready_c[NR+1] = !m_valid_reg || m_ready;
    assign out_ks        = stage_c[NR].st;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            out_mask[127 - 8*i -: 8] = (stage_c[NR].nbytes > 5'(i)) ? 8'hff : 8'h00;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ready_c[NR+1]) begin
            m_valid_reg <= valid_c[NR];
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_c[NR+1] && valid_c[NR]) begin
            result_reg       <= (stage_c[NR].data ^ out_ks) & out_mask;
            result_bytes_reg <= stage_c[NR].nbytes;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_upper = result_reg[127:64];
    assign m_result_lower = result_reg[63:0];
    assign m_result_bytes = result_bytes_reg;

`ifndef SYNTHESIS
    a_ctr_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_restart |=> ctr_reg ==
            $past({ctr_start_upper_reg, ctr_start_lower_reg}) + 128'd1)
        else $error("counter not reloaded on restart");
    a_ctr_step: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !s_restart |=> ctr_reg == $past(ctr_reg) + 128'd1)
        else $error("counter did not advance");
    a_ctr_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_accept |=> $stable(ctr_reg))
        else $error("counter moved without a transfer");
    a_warm: assert property (@(posedge aclk) disable iff (!aresetn)
        !warm_done |-> !s_ready)
        else $error("input ready before key schedule filled");
`endif

endmodule

// ===== bench/tb_aes128_ctr_keystream_xor_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aes128_ctr_keystream_xor_core
// Self-checking bench for the AES-128 CTR keystream XOR core.
// ----------------------------------------------------------------------------
// A local AES-128 cipher and counter predict every output block. Stimulus is
// driven over the input channel with random gaps, and the output side applies
// random backpressure plus one long hold-off. Results are checked in order.
// Key and counter registers change between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb_aes128_ctr_keystream_xor_core import aesctr_pkg::*; ();

    typedef struct {
        logic [63:0] upper;
        logic [63:0] lower;
        logic [4:0]  nbytes;
    } ctr_block_t;

    // Software view of the core: cipher, key schedule and counter
    class keystream_scoreboard;
        logic [127:0] key;
        logic [127:0] ctr_start;
        logic [127:0] ctr;
        logic [127:0] round_keys [11];
        ctr_block_t   pending [$];
        int           errors;
        int           checked;

        function new();
            key = '0;
            ctr_start = '0;
            ctr = '0;
            errors = 0;
            checked = 0;
            expand();
        endfunction

        function logic [7:0] mul2(logic [7:0] x);
            return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
        endfunction

        function void expand();
            logic [31:0] w [44];
            logic [31:0] t;
            for (int i = 0; i < 4; i++) w[i] = key[127 - 32*i -: 32];
            for (int i = 4; i < 44; i++) begin
                t = w[i-1];
                if (i % 4 == 0) begin
                    t = {SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]], SBOX[t[31:24]]};
                    t[31:24] ^= RCON[i/4];
                end
                w[i] = w[i-4] ^ t;
            end
            for (int r = 0; r < 11; r++)
                round_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
        endfunction

        function logic [127:0] cipher(logic [127:0] blk);
            logic [7:0] s [16];
            logic [7:0] t [16];
            logic [7:0] a, b, c, d, x;
            logic [127:0] o;
            o = blk ^ round_keys[0];
            for (int r = 1; r <= 10; r++) begin
                for (int i = 0; i < 16; i++) s[i] = o[127 - 8*i -: 8];
                for (int col = 0; col < 4; col++)
                    for (int row = 0; row < 4; row++)
                        t[col*4 + row] = SBOX[s[((col + row) % 4)*4 + row]];
                if (r != 10) begin
                    for (int col = 0; col < 4; col++) begin
                        a = t[col*4]; b = t[col*4+1]; c = t[col*4+2]; d = t[col*4+3];
                        x = a ^ b ^ c ^ d;
                        t[col*4]   = a ^ x ^ mul2(a ^ b);
                        t[col*4+1] = b ^ x ^ mul2(b ^ c);
                        t[col*4+2] = c ^ x ^ mul2(c ^ d);
                        t[col*4+3] = d ^ x ^ mul2(d ^ a);
                    end
                end
                for (int i = 0; i < 16; i++) o[127 - 8*i -: 8] = t[i];
                o ^= round_keys[r];
            end
            return o;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [63:0] v);
            case (idx)
                REG_KEY_UPPER: begin key[127:64] = v; expand(); end
                REG_KEY_LOWER: begin key[63:0] = v; expand(); end
                REG_CTR_UPPER: ctr_start[127:64] = v;
                REG_CTR_LOWER: ctr_start[63:0] = v;
                default: ;
            endcase
        endfunction

        // Note an accepted input transfer and queue its output block
        function void note_input(logic rst, logic [63:0] up, logic [63:0] lo,
                                 logic [4:0] n);
            logic [127:0] ks;
            logic [127:0] d;
            int lim;
            ctr_block_t e;
            if (rst) ctr = ctr_start;
            ks = cipher(ctr);
            d = {up, lo} ^ ks;
            lim = (n > 16) ? 16 : n;
            for (int i = 0; i < 16; i++)
                if (i >= lim) d[127 - 8*i -: 8] = 8'h00;
            ctr = ctr + 128'd1;
            e.upper = d[127:64];
            e.lower = d[63:0];
            e.nbytes = n;
            pending.push_back(e);
        endfunction

        // Compare one output transfer with the oldest expected block
        function void check_output(logic [63:0] up, logic [63:0] lo, logic [4:0] n);
            ctr_block_t e;
            if (pending.size() == 0) begin
                $display("%0t unexpected output: upper %h lower %h bytes %0d",
                         $time, up, lo, n);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (up !== e.upper) begin
                $display("%0t result_upper: expected %h actual %h", $time, e.upper, up);
                errors++;
            end
            if (lo !== e.lower) begin
                $display("%0t result_lower: expected %h actual %h", $time, e.lower, lo);
                errors++;
            end
            if (n !== e.nbytes) begin
                $display("%0t result_bytes: expected %0d actual %0d", $time, e.nbytes, n);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_restart = 1'b0;
    logic [63:0] s_block_upper = '0;
    logic [63:0] s_block_lower = '0;
    logic [4:0]  s_valid_bytes = 5'd16;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_result_upper;
    logic [63:0] m_result_lower;
    logic [4:0]  m_result_bytes;

    keystream_scoreboard sb = new();
    int  cycle_count = 0;
    bit  hold_off = 1'b0;
    bit  sink_on = 1'b0;
    int  blocks_sent = 0;
    int  restarts_sent = 0;
    int  partials_sent = 0;
    localparam int CYCLE_LIMIT = 400000;

    aes128_ctr_keystream_xor_core dut (.*);

    always #1 aclk = ~aclk;

    // Abort on runaway
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Monitor output transfers
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_output(m_result_upper, m_result_lower, m_result_bytes);
    end

    // Drive output backpressure: random stalls, mostly short
    always @(posedge aclk) begin
        if (!sink_on || hold_off)
            m_ready <= 1'b0;
        else if ($urandom_range(0, 99) < 8)
            m_ready <= 1'b0;
        else
            m_ready <= 1'b1;
    end

    // Long hold-off counted in its own process so the core fills and stalls
    initial begin
        wait (blocks_sent > 300);
        @(posedge aclk);
        hold_off = 1'b1;
        repeat (200) @(posedge aclk);
        hold_off = 1'b0;
    end

    // Write one register, then drop valid
    task automatic write_cfg(cfg_reg_t idx, logic [63:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, v);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_block(logic rst, logic [63:0] up, logic [63:0] lo, logic [4:0] n);
        s_valid       <= 1'b1;
        s_restart     <= rst;
        s_block_upper <= up;
        s_block_lower <= lo;
        s_valid_bytes <= n;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(rst, up, lo, n);
        blocks_sent++;
        if (rst) restarts_sent++;
        if (n < 16) partials_sent++;
    endtask

    task automatic idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return;
        s_valid <= 1'b0;
        if (r < 92) repeat ($urandom_range(1, 3)) @(posedge aclk);
        else repeat ($urandom_range(10, 40)) @(posedge aclk);
    endtask

    // Wait until every queued block is back, then let the pipeline settle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (sb.pending.size() == 0);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [4:0] rand_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 5'd16;
        if (r < 80) return 5'($urandom_range(17, 31));
        if (r < 83) return 5'd0;
        return 5'($urandom_range(1, 15));
    endfunction

    // Random stream of messages: usually a restart, full blocks, optional partial tail
    task automatic random_phase(int n_blocks, bit no_gaps);
        int sent;
        int len;
        sent = 0;
        while (sent < n_blocks) begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
                if (!no_gaps) idle_gap();
                send_block(i == 0 ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0),
                           rand64(), rand64(),
                           (i == len - 1) ? rand_count() : 5'd16);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        sink_on = 1'b1;

        // Directed: zero key, field extremes and counts 0 to 17 and 31
        send_block(1'b0, '0, '0, 5'd16);
        send_block(1'b0, '1, '1, 5'd16);
        send_block(1'b1, 64'h0123456789abcdef, 64'hfedcba9876543210, 5'd0);
        for (int n = 1; n <= 16; n++)
            send_block(1'b0, '1, '1, 5'(n));
        send_block(1'b0, '1, '1, 5'd17);
        send_block(1'b0, '1, '1, 5'd31);
        drain();

        // Standard test key and a counter just below wraparound
        write_cfg(REG_KEY_UPPER, 64'h2b7e151628aed2a6);
        write_cfg(REG_KEY_LOWER, 64'habf7158809cf4f3c);
        write_cfg(REG_CTR_UPPER, '1);
        write_cfg(REG_CTR_LOWER, 64'hffff_ffff_ffff_fffe);
        write_cfg(cfg_reg_t'(8'd9), 64'hdead_beef);
        send_block(1'b1, '0, '0, 5'd16);
        send_block(1'b0, '0, '0, 5'd16);
        send_block(1'b0, '0, '0, 5'd16);
        send_block(1'b0, rand64(), rand64(), 5'd16);
        drain();

        // Lower half carry into the upper half
        write_cfg(REG_CTR_UPPER, 64'h0);
        write_cfg(REG_CTR_LOWER, '1);
        send_block(1'b1, rand64(), rand64(), 5'd16);
        send_block(1'b0, rand64(), rand64(), 5'd16);
        random_phase(600, 1'b0);
        drain();

        // All-ones key and random counter, back-to-back traffic
        write_cfg(REG_KEY_UPPER, '1);
        write_cfg(REG_KEY_LOWER, '1);
        write_cfg(REG_CTR_UPPER, rand64());
        write_cfg(REG_CTR_LOWER, rand64());
        random_phase(400, 1'b1);
        drain();

        // Random keys and counters in several phases
        for (int p = 0; p < 4; p++) begin
            write_cfg(REG_KEY_UPPER, rand64());
            write_cfg(REG_KEY_LOWER, rand64());
            write_cfg(REG_CTR_UPPER, rand64());
            write_cfg(REG_CTR_LOWER, (p == 0) ? 64'hffff_ffff_ffff_fff0 : rand64());
            random_phase(250, 1'b0);
            drain();
        end

        $display("covered %0d blocks (%0d restarts, %0d short counts), %0d outputs checked",
                 blocks_sent, restarts_sent, partials_sent, sb.checked);
        $display("key and counter settings: zero, standard, all-ones and random");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/aesctr_pkg.sv
rtl/core/aesctr_cell.sv
rtl/core/aes128_ctr_keystream_xor_core.sv
bench/tb_aes128_ctr_keystream_xor_core.sv
